FILE: sv/sidx_pkg.sv
// Shared constants, types and helpers for the spectral index unit.
`default_nettype none

package sidx_pkg;

    localparam int LANES           = 5;
    localparam int OUT_W           = 16;
    localparam int QUO_W           = 17;
    localparam int COEF_W          = 16;
    localparam int COEF_FRAC       = 12;
    localparam int CFG_AW          = 2;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 12;

    localparam int LANE_NDVI = 0;
    localparam int LANE_NDWI = 1;
    localparam int LANE_NDBI = 2;
    localparam int LANE_BSI  = 3;
    localparam int LANE_EVI  = 4;

    localparam logic [OUT_W-1:0] OUT_POS_MAX = 16'h7FFF;
    localparam logic [OUT_W-1:0] OUT_NEG_MAX = 16'h8000;
    localparam logic [QUO_W-1:0] MAG_POS_MAX = 17'h07FFF;
    localparam logic [QUO_W-1:0] MAG_NEG_MAX = 17'h08000;

    localparam logic [COEF_W-1:0] EVI_GAIN_RST   = 16'd10240;
    localparam logic [COEF_W-1:0] EVI_RED_RST    = 16'd24576;
    localparam logic [COEF_W-1:0] EVI_BLUE_RST   = 16'd30720;
    localparam logic [COEF_W-1:0] EVI_OFFSET_RST = 16'd10000;

    typedef enum logic [CFG_AW-1:0] {
        REG_EVI_GAIN       = 2'd0,
        REG_EVI_RED_COEFF  = 2'd1,
        REG_EVI_BLUE_COEFF = 2'd2,
        REG_EVI_OFFSET     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [COEF_W-1:0] gain;
        logic [COEF_W-1:0] red_coeff;
        logic [COEF_W-1:0] blue_coeff;
        logic [COEF_W-1:0] offset;
    } evi_coef_t;

    typedef struct packed {
        logic [LANES-1:0] neg;
        logic [LANES-1:0] zero;
    } lane_flags_t;

    // signed width that holds every numerator and denominator
    function automatic int ext_width(input int sample_bits);
        int w;
        w = sample_bits + 18;
        return (w > 30) ? w : 30;
    endfunction

endpackage

`default_nettype wire

FILE: sv/sidx_front.sv
// Front end: differences, EVI products, EVI denominator, magnitudes and signs.
`default_nettype none

module sidx_front #(
    parameter int SAMPLE_BITS = sidx_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = sidx_pkg::FRAC_BITS_DEF
) (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire                                     in_valid,
    output logic                                    in_ready,
    input  wire  [sidx_pkg::LANES*SAMPLE_BITS-1:0]  in_data,
    input  sidx_pkg::evi_coef_t                     coef,
    output logic                                    out_valid,
    input  wire                                     out_ready,
    output logic [sidx_pkg::LANES-1:0][sidx_pkg::ext_width(SAMPLE_BITS)+FRAC_BITS
                                       +sidx_pkg::QUO_W-1:0] out_rem,
    output logic [sidx_pkg::LANES-1:0][sidx_pkg::ext_width(SAMPLE_BITS)-1:0] out_den,
    output sidx_pkg::lane_flags_t                   out_flags
);
    localparam int SB = SAMPLE_BITS;
    localparam int EW = sidx_pkg::ext_width(SAMPLE_BITS);
    localparam int RW = EW + FRAC_BITS + sidx_pkg::QUO_W;
    localparam int NL = sidx_pkg::LANES;

    logic signed [SB-1:0] b_s, g_s, r_s, n_s, s_s;
    logic signed [SB:0]   d_nr, a_nr, d_gn, a_gn, d_sn, a_sn, sr, nb;
    logic signed [SB+1:0] d_bsi, a_bsi;
    logic signed [SB+17:0] gain_p;
    logic signed [SB+16:0] red_p, blue_p;

    logic signed [EW-1:0] num1_next [NL];
    logic signed [EW-1:0] den1_next [NL-1];
    logic signed [EW-1:0] nsh_next, lsh_next;

    logic              v1_reg, v2_reg, v3_reg;
    logic              rdy1, rdy2, rdy3;
    logic signed [EW-1:0] num1_reg [NL];
    logic signed [EW-1:0] den1_reg [NL-1];
    logic signed [EW-1:0] nsh_reg, lsh_reg, red_reg, blue_reg;
    logic signed [EW-1:0] num2_reg [NL];
    logic signed [EW-1:0] den2_reg [NL];
    logic signed [EW-1:0] eden_next;

    logic [NL-1:0][RW-1:0] rem_next;
    logic [NL-1:0][EW-1:0] den_next;
    sidx_pkg::lane_flags_t flags_next;
    logic [NL-1:0][RW-1:0] rem3_reg;
    logic [NL-1:0][EW-1:0] den3_reg;
    sidx_pkg::lane_flags_t flags3_reg;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: band sums and differences, EVI products
    assign b_s = in_data[0*SB +: SB];
    assign g_s = in_data[1*SB +: SB];
    assign r_s = in_data[2*SB +: SB];
    assign n_s = in_data[3*SB +: SB];
    assign s_s = in_data[4*SB +: SB];

    assign d_nr  = (SB+1)'(n_s) - (SB+1)'(r_s);
    assign a_nr  = (SB+1)'(n_s) + (SB+1)'(r_s);
    assign d_gn  = (SB+1)'(g_s) - (SB+1)'(n_s);
    assign a_gn  = (SB+1)'(g_s) + (SB+1)'(n_s);
    assign d_sn  = (SB+1)'(s_s) - (SB+1)'(n_s);
    assign a_sn  = (SB+1)'(s_s) + (SB+1)'(n_s);
    assign sr    = (SB+1)'(s_s) + (SB+1)'(r_s);
    assign nb    = (SB+1)'(n_s) + (SB+1)'(b_s);
    assign d_bsi = (SB+2)'(sr) - (SB+2)'(nb);
    assign a_bsi = (SB+2)'(sr) + (SB+2)'(nb);

    assign gain_p = $signed({1'b0, coef.gain}) * d_nr;
    assign red_p  = $signed({1'b0, coef.red_coeff}) * r_s;
    assign blue_p = $signed({1'b0, coef.blue_coeff}) * b_s;

    always_comb begin
        num1_next[sidx_pkg::LANE_NDVI] = EW'(d_nr);
        num1_next[sidx_pkg::LANE_NDWI] = EW'(d_gn);
        num1_next[sidx_pkg::LANE_NDBI] = EW'(d_sn);
        num1_next[sidx_pkg::LANE_BSI]  = EW'(d_bsi);
        num1_next[sidx_pkg::LANE_EVI]  = EW'(gain_p);
        den1_next[sidx_pkg::LANE_NDVI] = EW'(a_nr);
        den1_next[sidx_pkg::LANE_NDWI] = EW'(a_gn);
        den1_next[sidx_pkg::LANE_NDBI] = EW'(a_sn);
        den1_next[sidx_pkg::LANE_BSI]  = EW'(a_bsi);
        nsh_next = EW'(n_s) <<< sidx_pkg::COEF_FRAC;
        lsh_next = EW'($signed(coef.offset)) <<< sidx_pkg::COEF_FRAC;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= in_valid;
        end
        if (rdy1 && in_valid) begin
            num1_reg <= num1_next;
            den1_reg <= den1_next;
            nsh_reg  <= nsh_next;
            lsh_reg  <= lsh_next;
            red_reg  <= EW'(red_p);
            blue_reg <= EW'(blue_p);
        end
    end

    // stage 2: EVI denominator in units of 2^-12 sample
    assign eden_next = nsh_reg + red_reg - blue_reg + lsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
        if (rdy2 && v1_reg) begin
            num2_reg <= num1_reg;
            for (int i = 0; i < NL - 1; i++) begin
                den2_reg[i] <= den1_reg[i];
            end
            den2_reg[sidx_pkg::LANE_EVI] <= eden_next;
        end
    end

    // stage 3: sign, zero test, magnitudes, aligned dividend
    always_comb begin
        logic [EW-1:0] nm;
        for (int i = 0; i < NL; i++) begin
            flags_next.neg[i]  = num2_reg[i][EW-1] ^ den2_reg[i][EW-1];
            flags_next.zero[i] = (den2_reg[i] == '0);
            nm          = num2_reg[i][EW-1] ? EW'(-num2_reg[i]) : EW'(num2_reg[i]);
            den_next[i] = den2_reg[i][EW-1] ? EW'(-den2_reg[i]) : EW'(den2_reg[i]);
            rem_next[i] = RW'(nm) << (FRAC_BITS + 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
        if (rdy3 && v2_reg) begin
            rem3_reg   <= rem_next;
            den3_reg   <= den_next;
            flags3_reg <= flags_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_rem   = rem3_reg;
    assign out_den   = den3_reg;
    assign out_flags = flags3_reg;

endmodule

`default_nettype wire

FILE: sv/sidx_div_step.sv
// One restoring-division step for all lanes: decides one quotient bit.
`default_nettype none

module sidx_div_step #(
    parameter int SAMPLE_BITS = sidx_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = sidx_pkg::FRAC_BITS_DEF,
    parameter int BIT         = 0
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire  [sidx_pkg::LANES-1:0][sidx_pkg::ext_width(SAMPLE_BITS)+FRAC_BITS
                                       +sidx_pkg::QUO_W-1:0] in_rem,
    input  wire  [sidx_pkg::LANES-1:0][sidx_pkg::ext_width(SAMPLE_BITS)-1:0] in_den,
    input  wire  [sidx_pkg::LANES-1:0][sidx_pkg::QUO_W-1:0] in_quo,
    input  sidx_pkg::lane_flags_t              in_flags,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [sidx_pkg::LANES-1:0][sidx_pkg::ext_width(SAMPLE_BITS)+FRAC_BITS
                                       +sidx_pkg::QUO_W-1:0] out_rem,
    output logic [sidx_pkg::LANES-1:0][sidx_pkg::ext_width(SAMPLE_BITS)-1:0] out_den,
    output logic [sidx_pkg::LANES-1:0][sidx_pkg::QUO_W-1:0] out_quo,
    output sidx_pkg::lane_flags_t              out_flags
);
    localparam int EW = sidx_pkg::ext_width(SAMPLE_BITS);
    localparam int RW = EW + FRAC_BITS + sidx_pkg::QUO_W;
    localparam int NL = sidx_pkg::LANES;

    logic                  v_reg;
    logic [NL-1:0][RW-1:0] rem_next, rem_reg;
    logic [NL-1:0][EW-1:0] den_reg;
    logic [NL-1:0][sidx_pkg::QUO_W-1:0] quo_next, quo_reg;
    sidx_pkg::lane_flags_t flags_reg;

    assign in_ready = !v_reg || out_ready;

    always_comb begin
        logic [RW-1:0] dsh;
        for (int i = 0; i < NL; i++) begin
            dsh = RW'(in_den[i]) << BIT;
            quo_next[i] = in_quo[i];
            if (in_rem[i] >= dsh) begin
                rem_next[i]      = in_rem[i] - dsh;
                quo_next[i][BIT] = 1'b1;
            end else begin
                rem_next[i] = in_rem[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            rem_reg   <= rem_next;
            den_reg   <= in_den;
            quo_reg   <= quo_next;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = v_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;
    assign out_flags = flags_reg;

endmodule

`default_nettype wire

FILE: sv/sidx_round.sv
// Output stage: round half away from zero, apply sign, saturate, zero-denominator rule.
`default_nettype none

module sidx_round (
    input  wire                                            aclk,
    input  wire                                            aresetn,
    input  wire                                            in_valid,
    output logic                                           in_ready,
    input  wire  [sidx_pkg::LANES-1:0][sidx_pkg::QUO_W-1:0] in_quo,
    input  sidx_pkg::lane_flags_t                          in_flags,
    output logic                                           out_valid,
    input  wire                                            out_ready,
    output logic [sidx_pkg::LANES*sidx_pkg::OUT_W-1:0]     out_data
);
    localparam int NL = sidx_pkg::LANES;
    localparam int OW = sidx_pkg::OUT_W;
    localparam int QW = sidx_pkg::QUO_W;

    logic                 v_reg;
    logic [NL*OW-1:0]     data_next, data_reg;

    assign in_ready = !v_reg || out_ready;

    always_comb begin
        logic [QW-1:0] m;
        for (int i = 0; i < NL; i++) begin
            // quotient carries one extra fraction bit; top bit means overflow
            m = ({1'b0, in_quo[i][QW-2:0]} + QW'(1)) >> 1;
            if (in_quo[i][QW-1]) begin
                m = sidx_pkg::MAG_NEG_MAX;
            end
            if (in_flags.zero[i]) begin
                data_next[i*OW +: OW] = '0;
            end else if (in_flags.neg[i]) begin
                data_next[i*OW +: OW] = (m >= sidx_pkg::MAG_NEG_MAX) ?
                    sidx_pkg::OUT_NEG_MAX : OW'(-m[OW-1:0]);
            end else begin
                data_next[i*OW +: OW] = (m >= sidx_pkg::MAG_POS_MAX) ?
                    sidx_pkg::OUT_POS_MAX : m[OW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: sv/spectral_index_unit.sv
// Top level of the spectral index unit: EVI registers, front end, divider pipeline, output.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata: blue, green, red, nir, swir samples
//  m_       | out       | m_tvalid/m_tready  | m_tdata: ndvi, ndwi, ndbi, bsi, evi (Q3.12)
//  cfg_     | in        | cfg_we (no wait)   | cfg_addr register index, cfg_wdata value
//
// One pixel per clock sustained while m_tready stays high. The pipeline has three
// front-end stages (differences and EVI products, EVI denominator sum, magnitudes),
// one stage per quotient bit for 17 bits, and the rounding/saturation output register.
// All five indices share those stages side by side in lanes.
// Reset (aresetn low, synchronous) empties the pipeline and loads the standard
// EVI coefficients. Each stage holds its item while the stage after it is full
// and stalled, and takes a new one as soon as it frees up, so bubbles collapse
// and a stalled m_ port backs up only as far as the pipeline is full.
`default_nettype none

module spectral_index_unit #(
    parameter int SAMPLE_BITS = sidx_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = sidx_pkg::FRAC_BITS_DEF
) (
    input  wire                                         aclk,
    input  wire                                         aresetn,
    // input pixel transfer
    input  wire                                         s_tvalid,
    output logic                                        s_tready,
    // blue, green, red, nir, swir (SAMPLE_BITS each), zero pad to bytes
    input  wire  [((sidx_pkg::LANES*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // result transfer
    output logic                                        m_tvalid,
    input  wire                                         m_tready,
    // ndvi, ndwi, ndbi, bsi, evi (16 bits each)
    output logic [sidx_pkg::LANES*sidx_pkg::OUT_W-1:0]  m_tdata,
    // configuration writes
    input  wire                                         cfg_we,
    input  wire  [sidx_pkg::CFG_AW-1:0]                 cfg_addr,
    input  wire  [sidx_pkg::COEF_W-1:0]                 cfg_wdata
);
    localparam int EW = sidx_pkg::ext_width(SAMPLE_BITS);
    localparam int RW = EW + FRAC_BITS + sidx_pkg::QUO_W;
    localparam int NL = sidx_pkg::LANES;
    localparam int QW = sidx_pkg::QUO_W;

    sidx_pkg::evi_coef_t coef_reg;

    // EVI coefficient registers; user rule, unenforced: written only while pipeline is idle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.gain       <= sidx_pkg::EVI_GAIN_RST;
            coef_reg.red_coeff  <= sidx_pkg::EVI_RED_RST;
            coef_reg.blue_coeff <= sidx_pkg::EVI_BLUE_RST;
            coef_reg.offset     <= sidx_pkg::EVI_OFFSET_RST;
        end else if (cfg_we) begin
            case (sidx_pkg::cfg_reg_t'(cfg_addr))
                sidx_pkg::REG_EVI_GAIN:       coef_reg.gain       <= cfg_wdata;
                sidx_pkg::REG_EVI_RED_COEFF:  coef_reg.red_coeff  <= cfg_wdata;
                sidx_pkg::REG_EVI_BLUE_COEFF: coef_reg.blue_coeff <= cfg_wdata;
                sidx_pkg::REG_EVI_OFFSET:     coef_reg.offset     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // divider pipeline links: index 0 is the front-end output
    logic                  st_valid [QW+1];
    logic                  st_ready [QW+1];
    logic [NL-1:0][RW-1:0] st_rem   [QW+1];
    logic [NL-1:0][EW-1:0] st_den   [QW+1];
    logic [NL-1:0][QW-1:0] st_quo   [QW+1];
    sidx_pkg::lane_flags_t st_flags [QW+1];

    sidx_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[NL*SAMPLE_BITS-1:0]),
        .coef      (coef_reg),
        .out_valid (st_valid[0]),
        .out_ready (st_ready[0]),
        .out_rem   (st_rem[0]),
        .out_den   (st_den[0]),
        .out_flags (st_flags[0])
    );

    assign st_quo[0] = '0;

    // one stage per quotient bit, most significant first
    for (genvar k = 0; k < QW; k++) begin : g_div
        sidx_div_step #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .FRAC_BITS   (FRAC_BITS),
            .BIT         (QW - 1 - k)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[k]),
            .in_ready  (st_ready[k]),
            .in_rem    (st_rem[k]),
            .in_den    (st_den[k]),
            .in_quo    (st_quo[k]),
            .in_flags  (st_flags[k]),
            .out_valid (st_valid[k+1]),
            .out_ready (st_ready[k+1]),
            .out_rem   (st_rem[k+1]),
            .out_den   (st_den[k+1]),
            .out_quo   (st_quo[k+1]),
            .out_flags (st_flags[k+1])
        );
    end

    sidx_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (st_valid[QW]),
        .in_ready  (st_ready[QW]),
        .in_quo    (st_quo[QW]),
        .in_flags  (st_flags[QW]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: dv/tb_spectral_index_unit.sv
// Self-checking testbench for the spectral index unit: random pixels, EVI register sweeps.
`default_nettype none

module tb_spectral_index_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // expected index tuple per accepted pixel, plus the EVI coefficients it is computed with
    class index_scoreboard;
        logic [79:0] pending_indices[$];
        logic [15:0] gain, red_coeff, blue_coeff, offset;
        int mismatches;
        int checked;

        function void load_defaults();
            gain       = sidx_pkg::EVI_GAIN_RST;
            red_coeff  = sidx_pkg::EVI_RED_RST;
            blue_coeff = sidx_pkg::EVI_BLUE_RST;
            offset     = sidx_pkg::EVI_OFFSET_RST;
        endfunction

        function void write_reg(sidx_pkg::cfg_reg_t idx, logic [15:0] val);
            case (idx)
                sidx_pkg::REG_EVI_GAIN:       gain = val;
                sidx_pkg::REG_EVI_RED_COEFF:  red_coeff = val;
                sidx_pkg::REG_EVI_BLUE_COEFF: blue_coeff = val;
                sidx_pkg::REG_EVI_OFFSET:     offset = val;
                default: ;
            endcase
        endfunction

        // round(num * 2^12 / den), ties away from zero, saturated to 16 bits
        function logic [15:0] ratio_q12(longint num, longint den);
            longint unsigned n, d, q, rem, m;
            bit neg;
            if (den == 0) return 16'd0;
            neg = (num < 0) != (den < 0);
            n = (num < 0) ? -num : num;
            d = (den < 0) ? -den : den;
            q = n / d;
            rem = n % d;
            if (q > 65535) begin
                m = 65536;
            end else begin
                for (int i = 0; i < 13; i++) begin
                    rem = rem << 1;
                    q = q << 1;
                    if (rem >= d) begin
                        rem = rem - d;
                        q = q | 1;
                    end
                end
                m = (q + 1) >> 1;
            end
            if (neg) begin
                if (m > 32768) m = 32768;
                return 16'(-m);
            end
            if (m > 32767) m = 32767;
            return 16'(m);
        endfunction

        function void note_pixel(logic [79:0] px);
            longint b, g, r, n, s, sr, nb, eden, enm;
            logic [79:0] res;
            b = longint'($signed(px[15:0]));
            g = longint'($signed(px[31:16]));
            r = longint'($signed(px[47:32]));
            n = longint'($signed(px[63:48]));
            s = longint'($signed(px[79:64]));
            sr = s + r;
            nb = n + b;
            eden = n * 4096 + longint'(red_coeff) * r - longint'(blue_coeff) * b
                 + longint'($signed(offset)) * 4096;
            enm = longint'(gain) * (n - r);
            res[15:0]  = ratio_q12(n - r, n + r);
            res[31:16] = ratio_q12(g - n, g + n);
            res[47:32] = ratio_q12(s - n, s + n);
            res[63:48] = ratio_q12(sr - nb, sr + nb);
            res[79:64] = ratio_q12(enm, eden);
            pending_indices = {pending_indices, res};
        endfunction

        function void check_result(logic [79:0] got);
            logic [79:0] exp_res;
            checked++;
            if (pending_indices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_res = pending_indices.pop_front();
            for (int k = 0; k < sidx_pkg::LANES; k++) begin
                if (got[k*16 +: 16] !== exp_res[k*16 +: 16]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d index %0d: expected %h got %h",
                                 checked, k, exp_res[k*16 +: 16], got[k*16 +: 16]);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    wire         s_tready;
    logic [79:0] s_tdata;
    wire         m_tvalid;
    logic        m_tready;
    wire  [79:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    index_scoreboard sb;
    longint cycles;
    bit     steady;       // no idling on either side during this stretch
    int     pixels_sent;
    int     settings_run;

    spectral_index_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog: ~2000 pixels, idling on both ends, many times over
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 200000) begin
                $display("timeout after %0d cycles", cycles);
                $display("[spectral_index_unit] ERROR");
                $finish;
            end
        end
    end

    // receiver: random back-pressure except during the steady stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 13);
        end
    end

    // one pixel transfer, with a random gap before it; tvalid stays up between
    // back-to-back transfers and is dropped only in a gap or by drain()
    task automatic send_pixel(logic [79:0] px);
        if (!steady) begin
            while ($urandom_range(99) < 13) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_pixel(px);
        pixels_sent++;
    endtask

    task automatic send_bands(int b, int g, int r, int n, int s);
        send_pixel({16'(s), 16'(n), 16'(r), 16'(g), 16'(b)});
    endtask

    // sample a band: mostly plausible reflectances, sometimes anything
    function automatic logic [15:0] band_value();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return ($urandom_range(1)) ? 16'h7FFF - 16'($urandom_range(3))
                                                : 16'h8000 + 16'($urandom_range(3));
            2:       return 16'($urandom_range(20));
            default: return 16'($urandom_range(10000));
        endcase
    endfunction

    // drain outstanding results, then let the pipeline settle before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_indices.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_cfg(sidx_pkg::cfg_reg_t idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic random_pixels(int count);
        for (int i = 0; i < count; i++) begin
            steady = (i >= count / 3) && (i < count / 3 + 60);
            send_pixel({band_value(), band_value(), band_value(), band_value(), band_value()});
        end
        steady = 1'b0;
    endtask

    initial begin
        sb = new();
        sb.load_defaults();
        steady = 1'b0;
        pixels_sent = 0;
        settings_run = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = sidx_pkg::REG_EVI_GAIN;
        cfg_wdata = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero denominators, saturation, negative samples
        send_bands(0, 0, 0, 0, 0);
        send_bands(32767, 32767, 32767, 32767, 32767);
        send_bands(-32768, -32768, -32768, -32768, -32768);
        send_bands(-32768, 32767, -32768, 32767, -32768);
        send_bands(32767, -32768, 32767, -32768, 32767);
        send_bands(500, 800, 600, 3000, 2000);       // vegetation
        send_bands(100, 1000, 1, -1, 5);             // n+r == 0
        send_bands(3, 1, 1, 2, 1);                   // tiny denominators
        send_bands(0, 0, 1, 0, 0);
        send_bands(0, 0, 0, 1, 0);
        send_bands(1, 3, 0, 1, 2);                   // exact halves for rounding
        send_bands(-100, -200, -300, 400, -500);
        send_bands(10000, 0, 10000, 10000, 0);
        send_bands(1333, 0, 0, 0, 0);                // EVI denominator: 7.5*1333 ~ L
        send_bands(-1333, -1, 1, 1, -1);
        send_bands(32767, 0, -32768, 0, 0);
        drain();
        settings_run++;

        // register settings, the extremes among them; last one back to defaults
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_cfg(sidx_pkg::REG_EVI_GAIN, 16'hFFFF);
                    write_cfg(sidx_pkg::REG_EVI_RED_COEFF, 16'h0000);
                    write_cfg(sidx_pkg::REG_EVI_BLUE_COEFF, 16'hFFFF);
                    write_cfg(sidx_pkg::REG_EVI_OFFSET, 16'h8000);
                end
                1: begin
                    write_cfg(sidx_pkg::REG_EVI_GAIN, 16'h0000);
                    write_cfg(sidx_pkg::REG_EVI_RED_COEFF, 16'hFFFF);
                    write_cfg(sidx_pkg::REG_EVI_BLUE_COEFF, 16'h0000);
                    write_cfg(sidx_pkg::REG_EVI_OFFSET, 16'h7FFF);
                end
                2: begin
                    // zero offset and coefficients: EVI denominator is nir alone
                    write_cfg(sidx_pkg::REG_EVI_GAIN, 16'd4096);
                    write_cfg(sidx_pkg::REG_EVI_RED_COEFF, 16'h0000);
                    write_cfg(sidx_pkg::REG_EVI_BLUE_COEFF, 16'h0000);
                    write_cfg(sidx_pkg::REG_EVI_OFFSET, 16'h0000);
                    send_bands(5, 5, 5, 0, 5);
                    send_bands(5, 5, -7, 0, 5);
                end
                3, 4: begin
                    write_cfg(sidx_pkg::REG_EVI_GAIN, 16'($urandom));
                    write_cfg(sidx_pkg::REG_EVI_RED_COEFF, 16'($urandom));
                    write_cfg(sidx_pkg::REG_EVI_BLUE_COEFF, 16'($urandom));
                    write_cfg(sidx_pkg::REG_EVI_OFFSET, 16'($urandom));
                end
                default: begin
                    write_cfg(sidx_pkg::REG_EVI_GAIN, sidx_pkg::EVI_GAIN_RST);
                    write_cfg(sidx_pkg::REG_EVI_RED_COEFF, sidx_pkg::EVI_RED_RST);
                    write_cfg(sidx_pkg::REG_EVI_BLUE_COEFF, sidx_pkg::EVI_BLUE_RST);
                    write_cfg(sidx_pkg::REG_EVI_OFFSET, sidx_pkg::EVI_OFFSET_RST);
                end
            endcase
            random_pixels(ph == 5 ? 640 : 250);
            drain();
            settings_run++;
        end

        $display("%0d pixels through %0d EVI register settings, %0d results checked",
                 pixels_sent, settings_run, sb.checked);
        if (sb.mismatches == 0 && sb.pending_indices.size() == 0) begin
            $display("[spectral_index_unit] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending_indices.size());
            $display("[spectral_index_unit] ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
